// ----- hw/rtl/rgbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbs_pkg
// Shared sizes, codes and types for the bilinear RGB scaler.
// ----------------------------------------------------------------------------
package rgbs_pkg;

    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;

    // Column and row index widths inside the frame store
    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);

    // Four banks split by column and row parity
    localparam int BANK_AW    = (XW - 1) + (YW - 1);
    localparam int BANK_DEPTH = 2 ** BANK_AW;
    localparam int NUM_BANKS  = 4;

    localparam int PIX_W    = 24;
    localparam int CH_W     = 8;
    localparam int COORD_W  = 10;
    localparam int STEP_W   = 24;
    localparam int SIZE_W   = 9;
    localparam int SCALED_W = 11;
    localparam int OFF_W    = 10;
    localparam int POS_W    = COORD_W + STEP_W;   // Q.16 source position
    localparam int INT_W    = POS_W - 16;         // integer part
    localparam int FRAC_W   = 8;
    localparam int GW       = FRAC_W + 1;         // 256 - f
    localparam int WGT_W    = 17;                 // weight product, max 65536
    localparam int PROD_W   = CH_W + WGT_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALED_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALED_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 3'd6;

    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [BANK_AW-1:0] bank_addr_t;

endpackage

// ----- hw/rtl/rgbs_frame_bank.sv -----
// ----------------------------------------------------------------------------
// rgbs_frame_bank
// One parity bank of the frame store: one write port, one registered read.
// ----------------------------------------------------------------------------
module rgbs_frame_bank
    import rgbs_pkg::*;
(
    input  logic       aclk,
    input  logic       we,
    input  bank_addr_t waddr,
    input  pixel_t     wdata,
    input  logic       re,
    input  bank_addr_t raddr,
    output pixel_t     rdata
);

    pixel_t mem [BANK_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/rgb_bilinear_scaler.sv -----
// ----------------------------------------------------------------------------
// rgb_bilinear_scaler
// Frame store with bilinear readout into a letterboxed canvas.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    tdata: coord_x, coord_y, blue, green, red
//                                     tuser: op (load / read)
//  m_       out  m_tvalid/m_tready    tdata: blue, green, red; tuser: in_window
//  cfg_     in   cfg_we               cfg_addr register index, cfg_wdata value
//
//  One beat per cycle on the input while the skid is empty, loads and reads
//  mixed freely. A read passes stages A to E and the output register; a load
//  gives no beat. The rate rests on the four parity banks of the frame store:
//  the 2x2 neighbourhood always hits each bank at most once, so all four pixels
//  come from one read of the banks. Loads write in the same stage as reads,
//  in order. Reset clears control only; the frame store needs no clearing
//  pass. A stalled output parks one result in a skid register; the pipeline
//  then halts until it drains.
// ----------------------------------------------------------------------------
module rgb_bilinear_scaler
    import rgbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // coord_x, coord_y, blue, green, red, pad
    input  logic                  s_tuser,   // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // out_blue, out_green, out_red
    output logic                  m_tuser,   // in_window
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0]   src_width_reg, src_height_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SCALED_W-1:0] scaled_width_reg, scaled_height_reg;
    logic [OFF_W-1:0]    offset_x_reg, offset_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg     <= SIZE_W'(256);
            src_height_reg    <= SIZE_W'(256);
            step_reg          <= STEP_W'(65536);
            scaled_width_reg  <= SCALED_W'(256);
            scaled_height_reg <= SCALED_W'(256);
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SRC_WIDTH:     src_width_reg     <= cfg_wdata[SIZE_W-1:0];
                REG_SRC_HEIGHT:    src_height_reg    <= cfg_wdata[SIZE_W-1:0];
                REG_STEP:          step_reg          <= cfg_wdata[STEP_W-1:0];
                REG_SCALED_WIDTH:  scaled_width_reg  <= cfg_wdata[SCALED_W-1:0];
                REG_SCALED_HEIGHT: scaled_height_reg <= cfg_wdata[SCALED_W-1:0];
                REG_OFFSET_X:      offset_x_reg      <= cfg_wdata[OFF_W-1:0];
                REG_OFFSET_Y:      offset_y_reg      <= cfg_wdata[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Last valid column / row: size 0 acts as 1, oversize saturates
    logic [XW-1:0] wm1;
    logic [YW-1:0] hm1;

    always_comb begin
        if (src_width_reg == '0) begin
            wm1 = '0;
        end else if (int'(src_width_reg) > MAX_SRC_WIDTH) begin
            wm1 = XW'(MAX_SRC_WIDTH - 1);
        end else begin
            wm1 = XW'(src_width_reg - SIZE_W'(1));
        end
        if (src_height_reg == '0) begin
            hm1 = '0;
        end else if (int'(src_height_reg) > MAX_SRC_HEIGHT) begin
            hm1 = YW'(MAX_SRC_HEIGHT - 1);
        end else begin
            hm1 = YW'(src_height_reg - SIZE_W'(1));
        end
    end

    // ---------------- pipeline control ----------------
    logic skid_valid_reg;
    logic en;

    // Whole pipeline advances together; it halts only while the skid is full
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- input field split ----------------
    logic [COORD_W-1:0] in_cx, in_cy;
    pixel_t             in_pix;
    logic [COORD_W-1:0] in_dx, in_dy;
    logic               in_win;

    assign in_cx  = s_tdata[9:0];
    assign in_cy  = s_tdata[19:10];
    assign in_pix = s_tdata[43:20];
    assign in_dx  = in_cx - offset_x_reg;
    assign in_dy  = in_cy - offset_y_reg;
    assign in_win = (in_cx >= offset_x_reg) && (in_cy >= offset_y_reg) &&
                    ({1'b0, in_dx} < scaled_width_reg) &&
                    ({1'b0, in_dy} < scaled_height_reg);

    // ---------------- stage A: accepted beat ----------------
    logic               a_valid_reg;
    logic               a_op_reg, a_win_reg;
    logic [COORD_W-1:0] a_cx_reg, a_cy_reg, a_dx_reg, a_dy_reg;
    pixel_t             a_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_op_reg  <= s_tuser;
            a_win_reg <= in_win;
            a_cx_reg  <= in_cx;
            a_cy_reg  <= in_cy;
            a_dx_reg  <= in_dx;
            a_dy_reg  <= in_dy;
            a_pix_reg <= in_pix;
        end
    end

    // ---------------- stage B: source position products ----------------
    logic               b_valid_reg;
    logic               b_op_reg, b_win_reg;
    logic [COORD_W-1:0] b_cx_reg, b_cy_reg;
    pixel_t             b_pix_reg;
    logic [POS_W-1:0]   b_px_reg, b_py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_op_reg  <= a_op_reg;
            b_win_reg <= a_win_reg;
            b_cx_reg  <= a_cx_reg;
            b_cy_reg  <= a_cy_reg;
            b_pix_reg <= a_pix_reg;
            b_px_reg  <= POS_W'(a_dx_reg) * POS_W'(step_reg);
            b_py_reg  <= POS_W'(a_dy_reg) * POS_W'(step_reg);
        end
    end

    // ---------------- stage C: neighbourhood indexes ----------------
    logic [INT_W-1:0] b_pxi, b_pyi;
    logic [XW-1:0]    ix_next, ix1_next;
    logic [YW-1:0]    iy_next, iy1_next;

    assign b_pxi = b_px_reg[POS_W-1:16];
    assign b_pyi = b_py_reg[POS_W-1:16];

    always_comb begin
        // Clamp a position past the frame to the last column / row
        ix_next  = (b_pxi > INT_W'(wm1)) ? wm1 : b_pxi[XW-1:0];
        iy_next  = (b_pyi > INT_W'(hm1)) ? hm1 : b_pyi[YW-1:0];
        ix1_next = (ix_next == wm1) ? wm1 : ix_next + XW'(1);
        iy1_next = (iy_next == hm1) ? hm1 : iy_next + YW'(1);
    end

    logic               c_valid_reg;
    logic               c_op_reg, c_win_reg;
    logic [COORD_W-1:0] c_cx_reg, c_cy_reg;
    pixel_t             c_pix_reg;
    logic [XW-1:0]      c_ix_reg, c_ix1_reg;
    logic [YW-1:0]      c_iy_reg, c_iy1_reg;
    logic [FRAC_W-1:0]  c_fx_reg, c_fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_op_reg  <= b_op_reg;
            c_win_reg <= b_win_reg;
            c_cx_reg  <= b_cx_reg;
            c_cy_reg  <= b_cy_reg;
            c_pix_reg <= b_pix_reg;
            c_ix_reg  <= ix_next;
            c_ix1_reg <= ix1_next;
            c_iy_reg  <= iy_next;
            c_iy1_reg <= iy1_next;
            c_fx_reg  <= b_px_reg[15:8];
            c_fy_reg  <= b_py_reg[15:8];
        end
    end

    // ---------------- frame store access ----------------
    // Bank {row parity, column parity}; each bank sees whichever of the two
    // neighbour columns / rows carries its parity.
    logic       ld_hit;
    logic [1:0] ld_bank;
    bank_addr_t ld_addr;
    pixel_t     bank_rd [NUM_BANKS];

    assign ld_hit  = c_valid_reg && (c_op_reg == OP_LOAD) &&
                     (int'(c_cx_reg) < MAX_SRC_WIDTH) && (int'(c_cy_reg) < MAX_SRC_HEIGHT);
    assign ld_bank = {c_cy_reg[0], c_cx_reg[0]};
    assign ld_addr = {c_cy_reg[YW-1:1], c_cx_reg[XW-1:1]};

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [XW-1:0] col;
        logic [YW-1:0] row;
        bank_addr_t    rd_addr;

        assign col     = (c_ix_reg[0] == b[0]) ? c_ix_reg : c_ix1_reg;
        assign row     = (c_iy_reg[0] == b[1]) ? c_iy_reg : c_iy1_reg;
        assign rd_addr = {row[YW-1:1], col[XW-1:1]};

        rgbs_frame_bank u_bank (
            .aclk  (aclk),
            .we    (en && ld_hit && (ld_bank == 2'(b))),
            .waddr (ld_addr),
            .wdata (c_pix_reg),
            .re    (en),
            .raddr (rd_addr),
            .rdata (bank_rd[b])
        );
    end

    // Bilinear weights, computed alongside the bank read
    logic [GW-1:0]    gx, gy;
    logic [WGT_W-1:0] w00_next, w01_next, w10_next, w11_next;

    assign gx       = GW'(256) - GW'(c_fx_reg);
    assign gy       = GW'(256) - GW'(c_fy_reg);
    assign w00_next = WGT_W'(gx) * WGT_W'(gy);
    assign w01_next = WGT_W'(c_fx_reg) * WGT_W'(gy);
    assign w10_next = WGT_W'(gx) * WGT_W'(c_fy_reg);
    assign w11_next = WGT_W'(c_fx_reg) * WGT_W'(c_fy_reg);

    // ---------------- stage D: bank data ----------------
    logic             d_valid_reg;
    logic             d_op_reg, d_win_reg;
    logic             d_x0_reg, d_x1_reg, d_y0_reg, d_y1_reg;
    logic [WGT_W-1:0] d_w_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_op_reg   <= c_op_reg;
            d_win_reg  <= c_win_reg;
            d_x0_reg   <= c_ix_reg[0];
            d_x1_reg   <= c_ix1_reg[0];
            d_y0_reg   <= c_iy_reg[0];
            d_y1_reg   <= c_iy1_reg[0];
            d_w_reg[0] <= w00_next;
            d_w_reg[1] <= w01_next;
            d_w_reg[2] <= w10_next;
            d_w_reg[3] <= w11_next;
        end
    end

    // Route bank outputs back to the four neighbour positions
    pixel_t nb [4];

    assign nb[0] = bank_rd[{d_y0_reg, d_x0_reg}];
    assign nb[1] = bank_rd[{d_y0_reg, d_x1_reg}];
    assign nb[2] = bank_rd[{d_y1_reg, d_x0_reg}];
    assign nb[3] = bank_rd[{d_y1_reg, d_x1_reg}];

    // ---------------- stage E: weighted channel terms ----------------
    logic              e_valid_reg;
    logic              e_op_reg, e_win_reg;
    logic [PROD_W-1:0] e_prod_reg [3][4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_op_reg  <= d_op_reg;
            e_win_reg <= d_win_reg;
            for (int ch = 0; ch < 3; ch++) begin
                for (int k = 0; k < 4; k++) begin
                    e_prod_reg[ch][k] <= PROD_W'(nb[k][ch*CH_W +: CH_W]) *
                                         PROD_W'(d_w_reg[k]);
                end
            end
        end
    end

    // Sum and truncate; black outside the window
    logic [23:0] res_data;
    logic        res_valid;

    always_comb begin
        logic [PROD_W-1:0] sum;
        res_data = '0;
        for (int ch = 0; ch < 3; ch++) begin
            sum = e_prod_reg[ch][0] + e_prod_reg[ch][1] +
                  e_prod_reg[ch][2] + e_prod_reg[ch][3];
            res_data[ch*CH_W +: CH_W] = e_win_reg ? sum[23:16] : '0;
        end
    end

    assign res_valid = en && e_valid_reg && (e_op_reg == OP_READ);

    // ---------------- output register and skid ----------------
    logic        m_valid_reg;
    logic [23:0] m_data_reg, skid_data_reg;
    logic        m_win_reg, skid_win_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // Drain the parked result first
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= res_valid;
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                m_data_reg <= skid_data_reg;
                m_win_reg  <= skid_win_reg;
            end
        end else if (!m_valid_reg || m_tready) begin
            m_data_reg <= res_data;
            m_win_reg  <= e_win_reg;
        end else begin
            skid_data_reg <= res_data;
            skid_win_reg  <= e_win_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_win_reg;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_bilinear_scaler: frame loads, letterboxed reads.
// A short table of loads and reads runs right after reset, with most results
// that follow directly from the reset settings typed in. Then a series of
// register settings, each with its source frame loaded in full (or only the
// pixels that a saturating step can reach), followed by mixed reads and
// reloads. Every read result is checked against a bit-true prediction.
// ----------------------------------------------------------------------------
module tb;
    import rgbs_pkg::*;

    localparam int STEP_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       in_window;
    } canvas_pix_t;

    typedef struct {
        logic       op;
        int         x;
        int         y;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        bit         typed;   // expected result given in the row
        canvas_pix_t want;
    } table_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rgb_bilinear_scaler dut (.*);

    // Shadow of the block: frame store and register file
    logic [PIX_W-1:0]    frame_mem [0:MAX_SRC_WIDTH*MAX_SRC_HEIGHT-1];
    logic [SIZE_W-1:0]   sh_src_w, sh_src_h;
    logic [STEP_W-1:0]   sh_step;
    logic [SCALED_W-1:0] sh_scaled_w, sh_scaled_h;
    logic [OFF_W-1:0]    sh_off_x, sh_off_y;

    canvas_pix_t pending_pix[$];
    int          n_items;
    int          send_idle, recv_idle;
    bit          failed;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("** rgb_bilinear_scaler: FAILED **");
        $finish;
    end

    function automatic int eff_size(logic [SIZE_W-1:0] v, int maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : int'(v);
    endfunction

    function automatic logic [7:0] blend_channel(logic [PIX_W-1:0] p00, p01, p10, p11,
                                                 int sh, int fx, int fy);
        int unsigned acc;
        acc = p00[sh +: 8] * (256 - fx) * (256 - fy) + p01[sh +: 8] * fx * (256 - fy)
            + p10[sh +: 8] * (256 - fx) * fy + p11[sh +: 8] * fx * fy;
        return acc[23:16];
    endfunction

    // Bilinear sample of the shadow frame at one canvas coordinate
    function automatic canvas_pix_t scale_pixel(int cx, int cy);
        canvas_pix_t res;
        logic [POS_W-1:0] px, py;
        int w, h, ix, iy, ix1, iy1, fx, fy;
        logic [PIX_W-1:0] p00, p01, p10, p11;
        res = '0;
        if (cx < sh_off_x || cy < sh_off_y ||
            cx - sh_off_x >= sh_scaled_w || cy - sh_off_y >= sh_scaled_h)
            return res;   // letterbox black
        w  = eff_size(sh_src_w, MAX_SRC_WIDTH);
        h  = eff_size(sh_src_h, MAX_SRC_HEIGHT);
        px = POS_W'(cx - sh_off_x) * POS_W'(sh_step);
        py = POS_W'(cy - sh_off_y) * POS_W'(sh_step);
        fx = px[15:8];
        fy = py[15:8];
        ix = (px[POS_W-1:16] > w - 1) ? w - 1 : int'(px[POS_W-1:16]);
        iy = (py[POS_W-1:16] > h - 1) ? h - 1 : int'(py[POS_W-1:16]);
        ix1 = (ix + 1 > w - 1) ? w - 1 : ix + 1;
        iy1 = (iy + 1 > h - 1) ? h - 1 : iy + 1;
        p00 = frame_mem[iy  * MAX_SRC_WIDTH + ix];
        p01 = frame_mem[iy  * MAX_SRC_WIDTH + ix1];
        p10 = frame_mem[iy1 * MAX_SRC_WIDTH + ix];
        p11 = frame_mem[iy1 * MAX_SRC_WIDTH + ix1];
        res.blue      = blend_channel(p00, p01, p10, p11, 0,  fx, fy);
        res.green     = blend_channel(p00, p01, p10, p11, 8,  fx, fy);
        res.red       = blend_channel(p00, p01, p10, p11, 16, fx, fy);
        res.in_window = 1'b1;
        return res;
    endfunction

    // Drive one beat, wait for it to be taken, then update the shadow.
    task automatic push_beat(logic op, int x, int y, logic [7:0] b, g, r,
                             bit typed, canvas_pix_t want);
        // idling regime follows the progress of the run
        if (n_items < 200) begin
            send_idle = 15; recv_idle = 48;
        end else if (n_items < 400) begin
            send_idle = 48; recv_idle = 15;
        end else begin
            send_idle = 0;  recv_idle = 0;
        end
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'h0, r, g, b, 10'(y), 10'(x)};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_READ) begin
            pending_pix.push_back(typed ? want : scale_pixel(x, y));
        end else if (x < MAX_SRC_WIDTH && y < MAX_SRC_HEIGHT) begin
            frame_mem[y * MAX_SRC_WIDTH + x] = {r, g, b};
        end
        n_items++;
        @(negedge aclk);
    endtask

    task automatic load_pix(int x, int y);
        push_beat(OP_LOAD, x, y, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:     sh_src_w    = val[SIZE_W-1:0];
            REG_SRC_HEIGHT:    sh_src_h    = val[SIZE_W-1:0];
            REG_STEP:          sh_step     = val[STEP_W-1:0];
            REG_SCALED_WIDTH:  sh_scaled_w = val[SCALED_W-1:0];
            REG_SCALED_HEIGHT: sh_scaled_h = val[SCALED_W-1:0];
            REG_OFFSET_X:      sh_off_x    = val[OFF_W-1:0];
            REG_OFFSET_Y:      sh_off_y    = val[OFF_W-1:0];
            default: ;   // unknown index is ignored
        endcase
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_pix.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);   // let trailing loads clear the pipe
    endtask

    // Receiver: random back-pressure at the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Result checker
    always @(posedge aclk) begin
        canvas_pix_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pix.size() == 0) begin
                $error("result beat with nothing expected: %h/%b", m_tdata, m_tuser);
                failed = 1'b1;
            end else begin
                want = pending_pix.pop_front();
                if (m_tdata[7:0] !== want.blue) begin
                    $error("out_blue: expected %h, got %h", want.blue, m_tdata[7:0]);
                    failed = 1'b1;
                end
                if (m_tdata[15:8] !== want.green) begin
                    $error("out_green: expected %h, got %h", want.green, m_tdata[15:8]);
                    failed = 1'b1;
                end
                if (m_tdata[23:16] !== want.red) begin
                    $error("out_red: expected %h, got %h", want.red, m_tdata[23:16]);
                    failed = 1'b1;
                end
                if (m_tuser !== want.in_window) begin
                    $error("in_window: expected %b, got %b", want.in_window, m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        table_row_t  dir_rows[$];
        table_row_t  row;
        int          w, h, n_reads, cx, cy;
        bit          sparse;
        int          edge_rows[3];

        failed    = 1'b0;
        n_items   = 0;
        send_idle = 15;
        recv_idle = 48;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_LOAD;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_SRC_WIDTH;
        cfg_wdata = '0;
        sh_src_w = 256; sh_src_h = 256; sh_step = 24'h010000;
        sh_scaled_w = 256; sh_scaled_h = 256; sh_off_x = 0; sh_off_y = 0;
        edge_rows = '{0, 1, 255};

        // Directed table, reset settings: 1:1 scale, window at the origin
        //            op       x     y     b      g      r      typed want
        dir_rows = '{
            '{OP_LOAD, 0,    0,    8'h00, 8'h00, 8'h00, 0, '0},
            '{OP_LOAD, 1,    0,    8'hFF, 8'hFF, 8'hFF, 0, '0},
            '{OP_LOAD, 0,    1,    8'h12, 8'h34, 8'h56, 0, '0},
            '{OP_LOAD, 1,    1,    8'hAB, 8'hCD, 8'hEF, 0, '0},
            '{OP_READ, 0,    0,    8'h00, 8'h00, 8'h00, 1, '{8'h00, 8'h00, 8'h00, 1'b1}},
            '{OP_LOAD, 0,    0,    8'hFF, 8'hFF, 8'hFF, 0, '0},
            '{OP_READ, 0,    0,    8'h00, 8'h00, 8'h00, 1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
            // loads off the store are dropped
            '{OP_LOAD, 256,  0,    8'h5A, 8'hA5, 8'h00, 0, '0},
            '{OP_LOAD, 0,    1023, 8'h00, 8'h5A, 8'hA5, 0, '0},
            '{OP_LOAD, 1023, 1023, 8'h01, 8'h02, 8'h03, 0, '0},
            '{OP_READ, 0,    0,    8'h00, 8'h00, 8'h00, 1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
            // bottom-right corner: all four neighbours clamp to one pixel
            '{OP_LOAD, 255,  255,  8'h80, 8'h7F, 8'h01, 0, '0},
            '{OP_READ, 255,  255,  8'h00, 8'h00, 8'h00, 1, '{8'h80, 8'h7F, 8'h01, 1'b1}},
            // letterbox black
            '{OP_READ, 256,  0,    8'h00, 8'h00, 8'h00, 1, '0},
            '{OP_READ, 0,    256,  8'h00, 8'h00, 8'h00, 1, '0},
            '{OP_READ, 1023, 1023, 8'h00, 8'h00, 8'h00, 1, '0},
            // fill the rest of the neighbourhood of (1, 1) before reading it
            '{OP_LOAD, 2,    1,    8'h11, 8'h22, 8'h33, 0, '0},
            '{OP_LOAD, 1,    2,    8'h44, 8'h55, 8'h66, 0, '0},
            '{OP_LOAD, 2,    2,    8'h77, 8'h88, 8'h99, 0, '0},
            '{OP_READ, 1,    1,    8'h00, 8'h00, 8'h00, 0, '0}
        };

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            push_beat(row.op, row.x, row.y, row.b, row.g, row.r, row.typed, row.want);
        end

        // Random phases, one register setting each
        for (int phase = 0; n_items < 600; phase++) begin
            drain_results();
            sparse = 1'b0;
            case (phase)
                0: begin   // largest frame, saturating size, top step, full canvas
                    set_reg(REG_SRC_WIDTH, 511);
                    set_reg(REG_SRC_HEIGHT, 256);
                    set_reg(REG_STEP, STEP_MAX);
                    set_reg(REG_SCALED_WIDTH, 1024);
                    set_reg(REG_SCALED_HEIGHT, 1024);
                    set_reg(REG_OFFSET_X, 0);
                    set_reg(REG_OFFSET_Y, 0);
                    sparse = 1'b1;
                end
                1: begin   // smallest window at the far corner, smallest step
                    set_reg(REG_SRC_WIDTH, 2);
                    set_reg(REG_SRC_HEIGHT, 2);
                    set_reg(REG_STEP, 1);
                    set_reg(REG_SCALED_WIDTH, 1);
                    set_reg(REG_SCALED_HEIGHT, 1);
                    set_reg(REG_OFFSET_X, 1023);
                    set_reg(REG_OFFSET_Y, 1023);
                end
                2: begin   // zero sizes act as one; write an unknown index
                    set_reg(REG_SRC_WIDTH, 0);
                    set_reg(REG_SRC_HEIGHT, 0);
                    set_reg(3'd7, CFG_DATA_W'($urandom));
                    set_reg(REG_STEP, 24'($urandom));
                    set_reg(REG_SCALED_WIDTH, 2047);
                    set_reg(REG_SCALED_HEIGHT, $urandom_range(1, 64));
                    set_reg(REG_OFFSET_X, $urandom_range(0, 64));
                    set_reg(REG_OFFSET_Y, 0);
                end
                default: begin
                    if ($urandom_range(5) == 0) begin
                        set_reg(REG_SRC_WIDTH, $urandom_range(256, 511));
                        set_reg(REG_SRC_HEIGHT, $urandom_range(256, 511));
                        set_reg(REG_STEP, $urandom_range(24'hFF0000, STEP_MAX));
                        sparse = 1'b1;
                    end else begin
                        set_reg(REG_SRC_WIDTH, $urandom_range(0, 9));
                        set_reg(REG_SRC_HEIGHT, $urandom_range(0, 9));
                        set_reg(REG_STEP, ($urandom_range(1) == 0) ?
                                $urandom_range(1, 24'h03FFFF) : 24'($urandom));
                    end
                    set_reg(REG_SCALED_WIDTH, $urandom_range(1, 1024));
                    set_reg(REG_SCALED_HEIGHT, $urandom_range(1, 1024));
                    set_reg(REG_OFFSET_X, $urandom_range(0, 1023));
                    set_reg(REG_OFFSET_Y, $urandom_range(0, 1023));
                end
            endcase

            w = eff_size(sh_src_w, MAX_SRC_WIDTH);
            h = eff_size(sh_src_h, MAX_SRC_HEIGHT);

            // Fill every pixel the reads of this setting can reach
            if (sparse) begin
                foreach (edge_rows[j]) foreach (edge_rows[k]) load_pix(edge_rows[k], edge_rows[j]);
            end else begin
                for (int y = 0; y < h; y++) for (int x = 0; x < w; x++) load_pix(x, y);
            end

            n_reads = $urandom_range(30, 60);
            for (int i = 0; i < n_reads; i++) begin
                case ($urandom_range(9))
                    0: begin   // reload a reachable pixel
                        if (sparse) load_pix(edge_rows[$urandom_range(2)],
                                             edge_rows[$urandom_range(2)]);
                        else load_pix($urandom_range(w - 1), $urandom_range(h - 1));
                    end
                    1: begin   // noise: load off the store
                        push_beat(OP_LOAD, $urandom_range(256, 1023), $urandom_range(1023),
                                  8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
                    end
                    2, 3: begin   // anywhere on the canvas
                        push_beat(OP_READ, $urandom_range(1023), $urandom_range(1023),
                                  8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
                    end
                    default: begin   // inside the window, near its edges often
                        cx = sh_off_x + (($urandom_range(3) == 0) ? sh_scaled_w - 1 :
                                         $urandom_range(sh_scaled_w - 1));
                        cy = sh_off_y + (($urandom_range(3) == 0) ? sh_scaled_h - 1 :
                                         $urandom_range(sh_scaled_h - 1));
                        if (cx > 1023) cx = 1023;
                        if (cy > 1023) cy = 1023;
                        push_beat(OP_READ, cx, cy,
                                  8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
                    end
                endcase
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (!failed && pending_pix.size() == 0) begin
            $display("** rgb_bilinear_scaler: PASSED **");
        end else begin
            $display("** rgb_bilinear_scaler: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rgbs_pkg.sv
hw/rtl/rgbs_frame_bank.sv
hw/rtl/rgb_bilinear_scaler.sv
tb/sv/tb.sv
